// ===== rtl/isq_pkg.sv =====
package isq_pkg;

    // Operand and recurrence sizes
    localparam int OP_W     = 48;
    localparam int ROOT_W   = 24;
    localparam int VALUE_W  = 32;
    localparam int STEPS    = 24;
    localparam int TOP_BIT  = 46;
    localparam int Q_SHIFT  = 16;

    // Operation codes
    localparam logic FUNC_INT = 1'b0;
    localparam logic FUNC_Q16 = 1'b1;

    // Word handed from cell to cell
    typedef struct packed {
        logic [OP_W-1:0] rem;
        logic [OP_W-1:0] acc;
    } isq_data_t;

endpackage

// ===== rtl/integer_and_q16_square_root.sv =====
// Floor square root of a 32-bit unsigned word, as a plain integer (s_func = 0,
// root up to 65535) or as Q16.16 (s_func = 1, operand taken as value << 16,
// root in Q8.16 up to 24 bits). The root comes from a chain of 24 cells, one
// restoring digit-by-digit step each, every cell registered. A word can be
// accepted on every clock while roots are taken at the output; each word's
// root passes through the 24 cell registers in turn and then shows on m_valid.
// Each cell holds its word on stall and empty cells are filled, so the input
// keeps taking words while a finished root waits on the output, until all 24
// cells hold a word. No state beyond the pipeline; reset only clears the valid
// bits.
module integer_and_q16_square_root (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [isq_pkg::VALUE_W-1:0] s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [isq_pkg::ROOT_W-1:0]  m_root
);

    logic               valid_c [isq_pkg::STEPS+1];
    logic               ready_c [isq_pkg::STEPS+1];
    isq_pkg::isq_data_t data_c  [isq_pkg::STEPS+1];
    isq_pkg::isq_data_t operand;

    // Build the 48-bit operand from the selector
    always_comb begin
        operand.acc = '0;
        unique case (s_func)
            isq_pkg::FUNC_Q16: operand.rem =
                {s_value, {isq_pkg::Q_SHIFT{1'b0}}};
            default:           operand.rem =
                {{(isq_pkg::OP_W-isq_pkg::VALUE_W){1'b0}}, s_value};
        endcase
    end

    assign data_c[0]  = operand;
    assign valid_c[0] = s_valid;
    assign s_ready    = ready_c[0];

    // Chain of step cells
    for (genvar i = 0; i < isq_pkg::STEPS; i++) begin : g_cell
        isq_cell #(
            .STEP(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (valid_c[i]),
            .in_ready (ready_c[i]),
            .in_data  (data_c[i]),
            .out_valid(valid_c[i+1]),
            .out_ready(ready_c[i+1]),
            .out_data (data_c[i+1])
        );
    end

    assign ready_c[isq_pkg::STEPS] = m_ready;
    assign m_valid = valid_c[isq_pkg::STEPS];
    assign m_root  = data_c[isq_pkg::STEPS].acc[isq_pkg::ROOT_W-1:0];

    // Reset empties the chain
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    // An empty output cell lets the whole chain move
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output stage is empty");

    // A taken result frees every cell up to the input
    a_take_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |-> s_ready)
        else $error("input stalled while output word is taken");

endmodule

// ===== rtl/isq_cell.sv =====
module isq_cell #(
    parameter int STEP = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  isq_pkg::isq_data_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output isq_pkg::isq_data_t out_data
);

    // Trial bit of this step: a fixed power of four
    localparam logic [isq_pkg::OP_W-1:0] TRIAL =
        isq_pkg::OP_W'(1) << (isq_pkg::TOP_BIT - 2 * STEP);

    logic               valid_reg;
    isq_pkg::isq_data_t data_reg;
    isq_pkg::isq_data_t data_next;
    logic [isq_pkg::OP_W-1:0] sum;
    logic               take;
    logic               load;

    // One restoring step: subtract (acc + trial) when it fits
    always_comb begin
        sum  = in_data.acc + TRIAL;
        take = (in_data.rem >= sum);
        if (take) begin
            data_next.rem = in_data.rem - sum;
            data_next.acc = (in_data.acc >> 1) + TRIAL;
        end else begin
            data_next.rem = in_data.rem;
            data_next.acc = in_data.acc >> 1;
        end
    end

    // Stage holds a word until the next cell takes it; bubbles collapse
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
